FILE: hw/rtl/i4p_pkg.sv
// Shared types, mode codes and constants of the 4x4 intra predictor.
package i4p_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned KindW  = 4;
  localparam int unsigned EdgeW  = 8 * ByteW;
  localparam int unsigned RowW   = 4 * ByteW;
  localparam logic [ByteW-1:0] MidGrey = 8'd128;

  typedef enum logic [KindW-1:0] {
    MODE_VERT    = 4'd0,
    MODE_HORZ    = 4'd1,
    MODE_DC      = 4'd2,
    MODE_LEFT_DC = 4'd3,
    MODE_TOP_DC  = 4'd4,
    MODE_FLAT    = 4'd5,
    MODE_DL      = 4'd6,
    MODE_DR      = 4'd7,
    MODE_VR      = 4'd8,
    MODE_HD      = 4'd9,
    MODE_VL      = 4'd10,
    MODE_HU      = 4'd11,
    MODE_DL_ND   = 4'd12,
    MODE_HU_ND   = 4'd13,
    MODE_VL_ND   = 4'd14
  } mode_e;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [EdgeW-1:0] top_row;
    logic [EdgeW-1:0] left_col;
    logic [ByteW-1:0] corner;
    logic             right_missing;
  } pred_in_t;

  typedef struct packed {
    logic [RowW-1:0] row3;
    logic [RowW-1:0] row2;
    logic [RowW-1:0] row1;
    logic [RowW-1:0] row0;
  } pred_out_t;

endpackage

FILE: hw/rtl/i4p_if.sv
// Valid/ready channels carrying neighbor words in and predicted blocks out.
interface i4p_in_if import i4p_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [EdgeW-1:0] top_row;
  logic [EdgeW-1:0] left_col;
  logic [ByteW-1:0] corner;
  logic             right_missing;

  modport source (output valid, kind, top_row, left_col, corner, right_missing,
                  input ready);
  modport sink   (input valid, kind, top_row, left_col, corner, right_missing,
                  output ready);
endinterface

interface i4p_out_if import i4p_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [RowW-1:0] row0;
  logic [RowW-1:0] row1;
  logic [RowW-1:0] row2;
  logic [RowW-1:0] row3;

  modport source (output valid, row0, row1, row2, row3, input ready);
  modport sink   (input valid, row0, row1, row2, row3, output ready);
endinterface

FILE: hw/rtl/i4p_core.sv
// Combinational 4x4 block prediction from one registered neighbor word.
module i4p_core import i4p_pkg::*; (
  input  pred_in_t  pred_i,
  output pred_out_t pred_o
);

  logic [ByteW-1:0] t  [8];
  logic [ByteW-1:0] l  [8];
  logic [ByteW-1:0] lx [8];
  logic [ByteW-1:0] ed [9];
  logic [ByteW-1:0] dl [7];
  logic [ByteW-1:0] dr [1:7];
  logic [ByteW-1:0] b  [4][4];
  logic [ByteW-1:0] lt;
  logic             nodown;
  logic [10:0]      t_sum;
  logic [10:0]      l_sum;

  function automatic logic [10:0] e11(input logic [ByteW-1:0] x);
    return {3'b000, x};
  endfunction

  function automatic logic [10:0] s3(input logic [ByteW-1:0] a, x, c);
    return e11(a) + (e11(x) << 1) + e11(c);
  endfunction

  function automatic logic [ByteW-1:0] rnd8(input logic [10:0] s);
    logic [10:0] v;
    v = s + 11'd4;
    return v[10:3];
  endfunction

  function automatic logic [ByteW-1:0] rnd4(input logic [10:0] s);
    logic [10:0] v;
    v = s + 11'd2;
    return v[9:2];
  endfunction

  function automatic logic [ByteW-1:0] avg2(input logic [ByteW-1:0] a, c);
    logic [10:0] v;
    v = e11(a) + e11(c) + 11'd1;
    return v[8:1];
  endfunction

  function automatic logic [ByteW-1:0] avg3(input logic [ByteW-1:0] a, x, c);
    return rnd4(s3(a, x, c));
  endfunction

  assign lt     = pred_i.corner;
  assign nodown = (pred_i.kind == MODE_DL_ND) || (pred_i.kind == MODE_HU_ND) ||
                  (pred_i.kind == MODE_VL_ND);

  // Unpack neighbors; substitute T3 on the right when right_missing, L3 below for no-down modes.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      t[i] = pred_i.top_row[ByteW*i +: ByteW];
      l[i] = pred_i.left_col[ByteW*i +: ByteW];
      if (pred_i.right_missing && i >= 4) begin
        t[i] = pred_i.top_row[ByteW*3 +: ByteW];
      end
      lx[i] = (nodown && i >= 4) ? l[3] : l[i];
    end
  end

  always_comb begin
    ed[0] = l[3]; ed[1] = l[2]; ed[2] = l[1]; ed[3] = l[0];
    ed[4] = lt;   ed[5] = t[0]; ed[6] = t[1]; ed[7] = t[2]; ed[8] = t[3];
    for (int k = 1; k < 8; k++) begin
      dr[k] = avg3(ed[k-1], ed[k], ed[k+1]);
    end
    for (int i = 0; i < 6; i++) begin
      dl[i] = rnd8(s3(t[i], t[i+1], t[i+2]) + s3(lx[i], lx[i+1], lx[i+2]));
    end
    dl[6] = rnd4(e11(t[6]) + e11(t[7]) + e11(lx[6]) + e11(lx[7]));
    t_sum = e11(t[0]) + e11(t[1]) + e11(t[2]) + e11(t[3]);
    l_sum = e11(l[0]) + e11(l[1]) + e11(l[2]) + e11(l[3]);
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        b[r][c] = MidGrey;
      end
    end
    case (pred_i.kind)
      MODE_VERT: begin
        for (int r = 0; r < 4; r++) begin
          for (int c = 0; c < 4; c++) b[r][c] = t[c];
        end
      end
      MODE_HORZ: begin
        for (int r = 0; r < 4; r++) begin
          for (int c = 0; c < 4; c++) b[r][c] = l[r];
        end
      end
      MODE_DC: begin
        for (int r = 0; r < 4; r++) begin
          for (int c = 0; c < 4; c++) b[r][c] = rnd8(t_sum + l_sum);
        end
      end
      MODE_LEFT_DC: begin
        for (int r = 0; r < 4; r++) begin
          for (int c = 0; c < 4; c++) b[r][c] = rnd4(l_sum);
        end
      end
      MODE_TOP_DC: begin
        for (int r = 0; r < 4; r++) begin
          for (int c = 0; c < 4; c++) b[r][c] = rnd4(t_sum);
        end
      end
      MODE_DL, MODE_DL_ND: begin
        for (int r = 0; r < 4; r++) begin
          for (int c = 0; c < 4; c++) b[r][c] = dl[r+c];
        end
      end
      MODE_DR: begin
        for (int r = 0; r < 4; r++) begin
          for (int c = 0; c < 4; c++) b[r][c] = dr[4+c-r];
        end
      end
      MODE_VR: begin
        b[0][0] = avg2(lt, t[0]);          b[2][1] = b[0][0];
        b[0][1] = avg2(t[0], t[1]);        b[2][2] = b[0][1];
        b[0][2] = avg2(t[1], t[2]);        b[2][3] = b[0][2];
        b[0][3] = avg2(t[2], t[3]);
        b[1][0] = avg3(l[0], lt, t[0]);    b[3][1] = b[1][0];
        b[1][1] = avg3(lt, t[0], t[1]);    b[3][2] = b[1][1];
        b[1][2] = avg3(t[0], t[1], t[2]);  b[3][3] = b[1][2];
        b[1][3] = avg3(t[1], t[2], t[3]);
        b[2][0] = avg3(lt, l[0], l[1]);
        b[3][0] = avg3(l[0], l[1], l[2]);
      end
      MODE_HD: begin
        b[0][0] = avg2(lt, l[0]);          b[1][2] = b[0][0];
        b[0][1] = avg3(l[0], lt, t[0]);    b[1][3] = b[0][1];
        b[0][2] = avg3(lt, t[0], t[1]);
        b[0][3] = avg3(t[0], t[1], t[2]);
        b[1][0] = avg2(l[0], l[1]);        b[2][2] = b[1][0];
        b[1][1] = avg3(lt, l[0], l[1]);    b[2][3] = b[1][1];
        b[2][0] = avg2(l[1], l[2]);        b[3][2] = b[2][0];
        b[2][1] = avg3(l[0], l[1], l[2]);  b[3][3] = b[2][1];
        b[3][0] = avg2(l[2], l[3]);
        b[3][1] = avg3(l[1], l[2], l[3]);
      end
      MODE_VL, MODE_VL_ND: begin
        b[0][0] = rnd8((e11(t[0]) << 1) + (e11(t[1]) << 1) + s3(l[1], l[2], l[3]));
        b[1][0] = rnd8(s3(t[0], t[1], t[2]) + s3(l[2], l[3], lx[4]));
        for (int c = 1; c < 4; c++) begin
          b[0][c]   = avg2(t[c], t[c+1]);
          b[2][c-1] = b[0][c];
          b[1][c]   = avg3(t[c], t[c+1], t[c+2]);
          b[3][c-1] = b[1][c];
        end
        b[2][3] = avg2(t[4], t[5]);
        b[3][3] = avg3(t[4], t[5], t[6]);
      end
      MODE_HU, MODE_HU_ND: begin
        b[0][0] = rnd8(s3(t[1], t[2], t[3]) + (e11(l[0]) << 1) + (e11(l[1]) << 1));
        b[0][1] = rnd8(s3(t[2], t[3], t[4]) + s3(l[0], l[1], l[2]));
        b[0][2] = rnd8(s3(t[3], t[4], t[5]) + (e11(l[1]) << 1) + (e11(l[2]) << 1));
        b[1][0] = b[0][2];
        b[0][3] = rnd8(s3(t[4], t[5], t[6]) + s3(l[1], l[2], l[3]));
        b[1][1] = b[0][3];
        b[1][2] = rnd8(s3(t[5], t[6], t[7]) + (e11(l[2]) << 1) + (e11(l[3]) << 1));
        b[2][0] = b[1][2];
        b[1][3] = rnd8(s3(t[6], t[7], t[7]) + s3(l[2], l[3], l[3]));
        b[2][1] = b[1][3];
        b[2][3] = avg3(l[3], lx[4], lx[5]);
        b[3][1] = b[2][3];
        b[3][0] = rnd4(e11(t[6]) + e11(t[7]) + e11(l[3]) + e11(lx[4]));
        b[2][2] = b[3][0];
        b[3][2] = avg2(lx[4], lx[5]);
        b[3][3] = avg3(lx[4], lx[5], lx[6]);
      end
      default: begin
      end
    endcase
  end

  assign pred_o.row0 = {b[0][3], b[0][2], b[0][1], b[0][0]};
  assign pred_o.row1 = {b[1][3], b[1][2], b[1][1], b[1][0]};
  assign pred_o.row2 = {b[2][3], b[2][2], b[2][1], b[2][0]};
  assign pred_o.row3 = {b[3][3], b[3][2], b[3][1], b[3][0]};

endmodule

FILE: hw/rtl/intra4x4_predictor.sv
// Top level of the 4x4 intra predictor: input register, predictor, result register.
//
// Input channel in_i carries one word per block: mode, eight top and eight left
// neighbor bytes, the corner byte and the right-missing flag. Output channel
// out_o returns one word of four packed rows per input word, in order.
// A word is moved at a rising edge with valid and ready both high.
// An accepted word waits in the input register, then passes the predictor into the
// result register and onto out_o once that register is empty or its word is taken.
// Throughput: one word per cycle while out_o takes words, set by the single
// combinational prediction stage between the two registers.
// Reset clears both valid flags; no word is held afterward.
// When out_o stalls, the result register holds, the input register fills,
// and in_i.ready falls once both stages hold a word; no word is dropped.
module intra4x4_predictor import i4p_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  i4p_in_if.sink    in_i,
  i4p_out_if.source out_o
);

  logic      in_vld_q;
  pred_in_t  in_q;
  logic      out_vld_q;
  pred_out_t out_q;
  pred_out_t pred_d;
  logic      adv;

  assign adv        = !out_vld_q || out_o.ready;
  assign in_i.ready = !in_vld_q || adv;

  i4p_core u_core (
    .pred_i (in_q),
    .pred_o (pred_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (adv) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q.kind          <= in_i.kind;
      in_q.top_row       <= in_i.top_row;
      in_q.left_col      <= in_i.left_col;
      in_q.corner        <= in_i.corner;
      in_q.right_missing <= in_i.right_missing;
    end
    if (adv && in_vld_q) begin
      out_q <= pred_d;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.row0  = out_q.row0;
  assign out_o.row1  = out_q.row1;
  assign out_o.row2  = out_q.row2;
  assign out_o.row3  = out_q.row3;

`ifndef SYNTH
  a_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && adv |=> out_vld_q)
    else $error("pending word not moved to result register");

  a_hold_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_o.ready && in_vld_q |=> in_vld_q && out_vld_q)
    else $error("word lost while output stalled");

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && !in_vld_q && !out_vld_q |-> ##2 out_vld_q)
    else $error("result missing two cycles after accept into empty pipe");

  a_ready_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> in_vld_q && out_vld_q)
    else $error("input stalled with a free stage");
`endif

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// Testbench of the 4x4 intra predictor: directed and random words, self-checking.
module tb;
  import i4p_pkg::*;

  localparam logic [KindW-1:0] KindSpare = 4'hF;

  class block_checker;
    pred_out_t   expected_blocks[$];
    int unsigned mismatches = 0;

    function automatic pred_out_t predict_block(pred_in_t w);
      int unsigned t[8];
      int unsigned l[8];
      int unsigned ed[9];
      int unsigned b[4][4];
      int unsigned lt, s, v, g;
      int k, r, c;
      logic [RowW-1:0] rows[4];
      for (k = 0; k < 8; k++) begin
        t[k] = 32'(w.top_row[8*k +: 8]);
        l[k] = 32'(w.left_col[8*k +: 8]);
      end
      lt = 32'(w.corner);
      if (w.right_missing) begin
        for (k = 4; k < 8; k++) t[k] = t[3];
      end
      for (r = 0; r < 4; r++) begin
        for (c = 0; c < 4; c++) b[r][c] = 32'(MidGrey);
      end
      case (w.kind)
        MODE_VERT: begin
          for (r = 0; r < 4; r++) for (c = 0; c < 4; c++) b[r][c] = t[c];
        end
        MODE_HORZ: begin
          for (r = 0; r < 4; r++) for (c = 0; c < 4; c++) b[r][c] = l[r];
        end
        MODE_DC, MODE_LEFT_DC, MODE_TOP_DC: begin
          if (w.kind == MODE_DC)
            v = (t[0] + t[1] + t[2] + t[3] + l[0] + l[1] + l[2] + l[3] + 4) >> 3;
          else if (w.kind == MODE_LEFT_DC)
            v = (l[0] + l[1] + l[2] + l[3] + 2) >> 2;
          else
            v = (t[0] + t[1] + t[2] + t[3] + 2) >> 2;
          for (r = 0; r < 4; r++) for (c = 0; c < 4; c++) b[r][c] = v;
        end
        MODE_DL: begin
          for (r = 0; r < 4; r++) begin
            for (c = 0; c < 4; c++) begin
              k = r + c;
              if (k == 6)
                b[r][c] = (t[6] + t[7] + l[6] + l[7] + 2) >> 2;
              else
                b[r][c] = (t[k] + 2 * t[k+1] + t[k+2]
                           + l[k] + 2 * l[k+1] + l[k+2] + 4) >> 3;
            end
          end
        end
        MODE_DL_ND: begin
          for (r = 0; r < 4; r++) begin
            for (c = 0; c < 4; c++) begin
              k = r + c;
              if (k == 6) begin
                b[r][c] = (t[6] + t[7] + 2 * l[3] + 2) >> 2;
              end else begin
                s = t[k] + 2 * t[k+1] + t[k+2] + 4;
                if (k == 0)
                  s += l[0] + 2 * l[1] + l[2];
                else if (k == 1)
                  s += l[1] + 2 * l[2] + l[3];
                else if (k == 2)
                  s += l[2] + 3 * l[3];
                else
                  s += 4 * l[3];
                b[r][c] = s >> 3;
              end
            end
          end
        end
        MODE_DR: begin
          ed[0] = l[3]; ed[1] = l[2]; ed[2] = l[1]; ed[3] = l[0]; ed[4] = lt;
          ed[5] = t[0]; ed[6] = t[1]; ed[7] = t[2]; ed[8] = t[3];
          for (r = 0; r < 4; r++) begin
            for (c = 0; c < 4; c++) begin
              k = 4 + c - r;
              b[r][c] = (ed[k-1] + 2 * ed[k] + ed[k+1] + 2) >> 2;
            end
          end
        end
        MODE_VR: begin
          v = (lt + t[0] + 1) >> 1;                    b[0][0] = v; b[2][1] = v;
          v = (t[0] + t[1] + 1) >> 1;                  b[0][1] = v; b[2][2] = v;
          v = (t[1] + t[2] + 1) >> 1;                  b[0][2] = v; b[2][3] = v;
          b[0][3] = (t[2] + t[3] + 1) >> 1;
          v = (l[0] + 2 * lt + t[0] + 2) >> 2;         b[1][0] = v; b[3][1] = v;
          v = (lt + 2 * t[0] + t[1] + 2) >> 2;         b[1][1] = v; b[3][2] = v;
          v = (t[0] + 2 * t[1] + t[2] + 2) >> 2;       b[1][2] = v; b[3][3] = v;
          b[1][3] = (t[1] + 2 * t[2] + t[3] + 2) >> 2;
          b[2][0] = (lt + 2 * l[0] + l[1] + 2) >> 2;
          b[3][0] = (l[0] + 2 * l[1] + l[2] + 2) >> 2;
        end
        MODE_HD: begin
          v = (lt + l[0] + 1) >> 1;                    b[0][0] = v; b[1][2] = v;
          v = (l[0] + 2 * lt + t[0] + 2) >> 2;         b[0][1] = v; b[1][3] = v;
          b[0][2] = (lt + 2 * t[0] + t[1] + 2) >> 2;
          b[0][3] = (t[0] + 2 * t[1] + t[2] + 2) >> 2;
          v = (l[0] + l[1] + 1) >> 1;                  b[1][0] = v; b[2][2] = v;
          v = (lt + 2 * l[0] + l[1] + 2) >> 2;         b[1][1] = v; b[2][3] = v;
          v = (l[1] + l[2] + 1) >> 1;                  b[2][0] = v; b[3][2] = v;
          v = (l[0] + 2 * l[1] + l[2] + 2) >> 2;       b[2][1] = v; b[3][3] = v;
          b[3][0] = (l[2] + l[3] + 1) >> 1;
          b[3][1] = (l[1] + 2 * l[2] + l[3] + 2) >> 2;
        end
        MODE_VL, MODE_VL_ND: begin
          g = (w.kind == MODE_VL) ? l[4] : l[3];
          b[0][0] = (2 * t[0] + 2 * t[1] + l[1] + 2 * l[2] + l[3] + 4) >> 3;
          b[1][0] = (t[0] + 2 * t[1] + t[2] + l[2] + 2 * l[3] + g + 4) >> 3;
          for (c = 1; c < 4; c++) begin
            v = (t[c] + t[c+1] + 1) >> 1;
            b[0][c] = v;
            b[2][c-1] = v;
            v = (t[c] + 2 * t[c+1] + t[c+2] + 2) >> 2;
            b[1][c] = v;
            b[3][c-1] = v;
          end
          b[2][3] = (t[4] + t[5] + 1) >> 1;
          b[3][3] = (t[4] + 2 * t[5] + t[6] + 2) >> 2;
        end
        MODE_HU, MODE_HU_ND: begin
          b[0][0] = (t[1] + 2 * t[2] + t[3] + 2 * l[0] + 2 * l[1] + 4) >> 3;
          b[0][1] = (t[2] + 2 * t[3] + t[4] + l[0] + 2 * l[1] + l[2] + 4) >> 3;
          v = (t[3] + 2 * t[4] + t[5] + 2 * l[1] + 2 * l[2] + 4) >> 3;
          b[0][2] = v; b[1][0] = v;
          v = (t[4] + 2 * t[5] + t[6] + l[1] + 2 * l[2] + l[3] + 4) >> 3;
          b[0][3] = v; b[1][1] = v;
          v = (t[5] + 2 * t[6] + t[7] + 2 * l[2] + 2 * l[3] + 4) >> 3;
          b[1][2] = v; b[2][0] = v;
          v = (t[6] + 3 * t[7] + l[2] + 3 * l[3] + 4) >> 3;
          b[1][3] = v; b[2][1] = v;
          if (w.kind == MODE_HU) begin
            v = (l[3] + 2 * l[4] + l[5] + 2) >> 2;     b[2][3] = v; b[3][1] = v;
            v = (t[6] + t[7] + l[3] + l[4] + 2) >> 2;  b[3][0] = v; b[2][2] = v;
            b[3][2] = (l[4] + l[5] + 1) >> 1;
            b[3][3] = (l[4] + 2 * l[5] + l[6] + 2) >> 2;
          end else begin
            b[2][3] = l[3]; b[3][1] = l[3];
            v = (t[6] + t[7] + 2 * l[3] + 2) >> 2;     b[3][0] = v; b[2][2] = v;
            b[3][2] = l[3]; b[3][3] = l[3];
          end
        end
        default: begin
        end
      endcase
      for (r = 0; r < 4; r++) begin
        for (c = 0; c < 4; c++) rows[r][8*c +: 8] = b[r][c][ByteW-1:0];
      end
      return {rows[3], rows[2], rows[1], rows[0]};
    endfunction

    function void note_word(pred_in_t w);
      expected_blocks.push_back(predict_block(w));
    endfunction

    task report(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    task check_block(input pred_out_t got);
      pred_out_t want;
      int r;
      if (expected_blocks.size() == 0) begin
        report($sformatf("block %h with nothing pending", got));
        return;
      end
      want = expected_blocks.pop_front();
      for (r = 0; r < 4; r++) begin
        if (got[r*RowW +: RowW] !== want[r*RowW +: RowW])
          report($sformatf("row%0d got %h want %h", r, got[r*RowW +: RowW],
                           want[r*RowW +: RowW]));
      end
    endtask
  endclass

  logic         clk_i;
  logic         rst_ni;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  int           hold_left = 0;
  pred_out_t    seen_block;
  block_checker board = new();

  i4p_in_if  in_if ();
  i4p_out_if out_if ();

  intra4x4_predictor uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic [EdgeW-1:0] rand_edge();
    logic [EdgeW-1:0] e;
    int style, k;
    style = $urandom_range(0, 99);
    for (k = 0; k < 8; k++) begin
      if (style < 70)
        e[8*k +: 8] = 8'($urandom_range(0, 255));
      else if (style < 85)
        e[8*k +: 8] = 8'($urandom_range(240, 255));
      else
        e[8*k +: 8] = 8'($urandom_range(0, 15));
    end
    return e;
  endfunction

  function automatic pred_in_t make_word(input logic [KindW-1:0] kind,
                                         input logic [EdgeW-1:0] top,
                                         input logic [EdgeW-1:0] left,
                                         input logic [ByteW-1:0] corner,
                                         input logic             rm);
    pred_in_t w;
    w.kind          = kind;
    w.top_row       = top;
    w.left_col      = left;
    w.corner        = corner;
    w.right_missing = rm;
    return w;
  endfunction

  function automatic pred_in_t rand_word();
    logic [EdgeW-1:0] top;
    top = rand_edge();
    return make_word(KindW'($urandom_range(0, 15)), top, rand_edge(),
                     top[ByteW-1:0] ^ ByteW'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)));
  endfunction

  task automatic send_word(input pred_in_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.kind          <= w.kind;
    in_if.top_row       <= w.top_row;
    in_if.left_col      <= w.left_col;
    in_if.corner        <= w.corner;
    in_if.right_missing <= w.right_missing;
    do @(posedge clk_i); while (!in_if.ready);
    board.note_word(w);
    @(negedge clk_i);
  endtask

  task automatic set_phase(input int send_pct, input int recv_pct, input int hold);
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    hold_left     = hold;
    @(negedge clk_i);
  endtask

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (!rst_ni) begin
        out_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      seen_block.row0 = out_if.row0;
      seen_block.row1 = out_if.row1;
      seen_block.row2 = out_if.row2;
      seen_block.row3 = out_if.row3;
      board.check_block(seen_block);
    end
  end

  initial begin
    int k;
    rst_ni              <= 1'b0;
    in_if.valid         <= 1'b0;
    in_if.kind          <= '0;
    in_if.top_row       <= '0;
    in_if.left_col      <= '0;
    in_if.corner        <= '0;
    in_if.right_missing <= 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    set_phase(33, 56, 0);

    for (k = 0; k < 16; k++)
      send_word(make_word(KindW'(k), rand_edge(), rand_edge(),
                          ByteW'($urandom_range(0, 255)), k[0]));
    send_word(make_word(MODE_DL, '1, '1, 8'hFF, 1'b0));
    send_word(make_word(MODE_VL, '1, '1, 8'hFF, 1'b0));
    send_word(make_word(MODE_HU, '1, '1, 8'hFF, 1'b0));
    send_word(make_word(MODE_HU_ND, '1, '1, 8'hFF, 1'b1));
    send_word(make_word(MODE_DR, '1, '1, 8'hFF, 1'b1));
    send_word(make_word(MODE_DC, '0, '0, 8'h00, 1'b0));
    send_word(make_word(MODE_DL_ND, '0, '0, 8'h00, 1'b1));
    send_word(make_word(KindSpare, '1, '0, 8'hFF, 1'b1));

    for (k = 0; k < 283; k++) send_word(rand_word());
    set_phase(56, 33, 0);
    for (k = 0; k < 283; k++) send_word(rand_word());
    set_phase(0, 0, 60);
    for (k = 0; k < 284; k++) send_word(rand_word());
    in_if.valid <= 1'b0;

    while (board.expected_blocks.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (board.mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
